// ===== src/tensor_gather_engine_top_macros.svh =====
// Assertion macros shared by the tensor gather engine RTL.
`ifndef TENSOR_GATHER_ENGINE_TOP_MACROS_SVH
`define TENSOR_GATHER_ENGINE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define TGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define TGE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGE_ASSERT(lbl, prop, msg)
`define TGE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/tge_pkg.sv =====
// Package: shared constants, codes and types of the tensor gather engine.
`timescale 1ns / 1ps
`default_nettype none
package tge_pkg;

  // Store geometry
  localparam int STORE_WORDS = 4096;
  localparam int MAX_INNER   = 64;
  localparam int WORD_BITS   = 64;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  // Fixed field widths
  localparam int LOAD_ADDR_W = 12;
  localparam int OUT_WORD_W  = 64;
  localparam int IDX_W       = 32;
  localparam int CNT_W       = 13;
  localparam int INNER_W     = 7;
  localparam int TOTAL_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Address arithmetic widths
  localparam int PROD_W = 2 * CNT_W;
  localparam int SPAN_W = PROD_W + INNER_W;
  localparam int OFF_W  = CNT_W + INNER_W;

  localparam logic [CNT_W-1:0] SLAB_LIMIT = '1;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_GATHER = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_OUTER   = 2'd0,
    REG_SRC_COUNT   = 2'd1,
    REG_SRC_INNER   = 2'd2,
    REG_INDEX_TOTAL = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MUL,
    ST_ADD,
    ST_RUN
  } state_t;

  // One store read launched by the controller
  typedef struct packed {
    logic valid;
    logic last;
    logic err;
  } tge_issue_t;

  // One word held in the output queue
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
    logic                 err;
  } tge_entry_t;

endpackage
`default_nettype wire

// ===== src/tge_in_if.sv =====
// Interface: input channel carrying load and gather words.
`timescale 1ns / 1ps
`default_nettype none
interface tge_in_if import tge_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [LOAD_ADDR_W-1:0]  load_address;
  logic [OUT_WORD_W-1:0]   load_word;
  logic signed [IDX_W-1:0] gather_index;

  modport source (output valid, operation, load_address, load_word, gather_index,
                  input ready);
  modport sink (input valid, operation, load_address, load_word, gather_index,
                output ready);
endinterface
`default_nettype wire

// ===== src/tge_out_if.sv =====
// Interface: result channel carrying gathered words.
`timescale 1ns / 1ps
`default_nettype none
interface tge_out_if import tge_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_WORD_W-1:0] out_word;
  logic                  last_of_slice;
  logic                  index_error;

  modport source (output valid, out_word, last_of_slice, index_error, input ready);
  modport sink (input valid, out_word, last_of_slice, index_error, output ready);
endinterface
`default_nettype wire

// ===== src/tge_cfg_if.sv =====
// Interface: configuration register write channel.
`timescale 1ns / 1ps
`default_nettype none
interface tge_cfg_if import tge_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/tensor_gather_engine_top.sv =====
// Top level: tensor gather engine, gathers slices of a source store along one axis.
// Load word: written to the store at the edge it is accepted, no result.
// Gather word: results follow the wrap, multiply and add states, then one per cycle while
//   the output queue has room; the next input word is taken only after the last read of
//   the slice, set by the wrap/multiply/add address pipeline and the single store read port.
// Reset (rst_n, synchronous, active low) clears counters and sets every config
//   register to 1; the store has no clear and reads undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module tensor_gather_engine_top import tge_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tge_in_if.sink     in_ch,
  tge_out_if.source  out_ch,
  tge_cfg_if.sink    cfg_ch
);

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 can_issue;
  tge_issue_t           issue;

  // address math and sequencing
  tge_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_operation    (in_ch.operation),
    .in_load_address (in_ch.load_address),
    .in_load_word    (in_ch.load_word),
    .in_gather_index (in_ch.gather_index),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .can_issue       (can_issue),
    .issue           (issue)
  );

  // source store
  tge_ram #(
    .DEPTH (STORE_WORDS),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue
  tge_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .rd_data   (ram_rdata),
    .can_issue (can_issue),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.out_word),
    .out_last  (out_ch.last_of_slice),
    .out_err   (out_ch.index_error)
  );

endmodule
`default_nettype wire

// ===== src/tge_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tge_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/tge_ctrl.sv =====
// Controller: config registers, slab counters, slice address math and read launch.
`timescale 1ns / 1ps
`default_nettype none
`include "tensor_gather_engine_top_macros.svh"
module tge_ctrl import tge_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input words
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_operation,
  input  wire logic [LOAD_ADDR_W-1:0]  in_load_address,
  input  wire logic [OUT_WORD_W-1:0]   in_load_word,
  input  wire logic [IDX_W-1:0]        in_gather_index,
  // config writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // store access
  output logic                         ram_we,
  output logic [ADDR_W-1:0]            ram_waddr,
  output logic [WORD_BITS-1:0]         ram_wdata,
  output logic [ADDR_W-1:0]            ram_raddr,
  // output queue handshake
  input  wire logic                    can_issue,
  output tge_issue_t                   issue
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   src_outer_r, src_count_r;
  logic [INNER_W-1:0] src_inner_r;
  logic [TOTAL_W-1:0] index_total_r;

  logic [CNT_W-1:0]   slab_number_r;
  logic [TOTAL_W-1:0] index_position_r;

  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   widx_r;
  logic               bad_r;
  logic [PROD_W-1:0]  prod_r;
  logic [INNER_W-1:0] inner_r;
  logic [SPAN_W-1:0]  base_r;
  logic [OFF_W-1:0]   off_r;
  logic [SPAN_W-1:0]  addr_r;
  logic [INNER_W-1:0] k_r;

  logic               accept;
  logic               cfg_we;
  logic [IDX_W:0]     idx_ext;
  logic [IDX_W:0]     wrapped;
  logic               wrap_bad;
  logic [INNER_W-1:0] inner_len;
  logic [TOTAL_W-1:0] total_eff;
  logic [TOTAL_W:0]   pos_inc;
  logic               issue_fire;
  logic               is_last;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // load words go straight to the store
  assign ram_we    = accept && (in_operation == OP_LOAD) &&
                     (32'(in_load_address) < 32'(STORE_WORDS));
  assign ram_waddr = ADDR_W'(in_load_address);
  assign ram_wdata = in_load_word[WORD_BITS-1:0];
  assign ram_raddr = addr_r[ADDR_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_outer_r   <= CNT_W'(1);
      src_count_r   <= CNT_W'(1);
      src_inner_r   <= INNER_W'(1);
      index_total_r <= TOTAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_OUTER:   src_outer_r   <= cfg_data[CNT_W-1:0];
        REG_SRC_COUNT:   src_count_r   <= cfg_data[CNT_W-1:0];
        REG_SRC_INNER:   src_inner_r   <= cfg_data[INNER_W-1:0];
        REG_INDEX_TOTAL: index_total_r <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // index wrap and range check
  always_comb begin
    idx_ext  = {idx_r[IDX_W-1], idx_r};
    wrapped  = idx_r[IDX_W-1] ? idx_ext + (IDX_W+1)'(src_count_r) : idx_ext;
    wrap_bad = wrapped[IDX_W] || (wrapped >= (IDX_W+1)'(src_count_r)) ||
               (slab_number_r >= src_outer_r);
    if (src_inner_r == '0) begin
      inner_len = INNER_W'(1);
    end else if (src_inner_r > INNER_W'(MAX_INNER)) begin
      inner_len = INNER_W'(MAX_INNER);
    end else begin
      inner_len = src_inner_r;
    end
    total_eff = (index_total_r == '0) ? TOTAL_W'(1) : index_total_r;
    pos_inc   = (TOTAL_W+1)'(index_position_r) + 1'b1;
  end

  // slab counters move on once per gather word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_number_r    <= '0;
      index_position_r <= '0;
    end else if (state_r == ST_WRAP) begin
      if (pos_inc >= (TOTAL_W+1)'(total_eff)) begin
        index_position_r <= '0;
        if (slab_number_r < SLAB_LIMIT) begin
          slab_number_r <= slab_number_r + 1'b1;
        end
      end else begin
        index_position_r <= pos_inc[TOTAL_W-1:0];
      end
    end
  end

  // address pipeline: wrap, multiply, add, then walk the slice
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) idx_r <= in_gather_index;
      end
      ST_WRAP: begin
        widx_r  <= wrapped[CNT_W-1:0];
        bad_r   <= wrap_bad;
        prod_r  <= PROD_W'(slab_number_r) * PROD_W'(src_count_r);
        inner_r <= inner_len;
      end
      ST_MUL: begin
        base_r <= SPAN_W'(prod_r) * SPAN_W'(inner_r);
        off_r  <= OFF_W'(widx_r) * OFF_W'(inner_r);
      end
      ST_ADD: begin
        addr_r <= base_r + SPAN_W'(off_r);
        k_r    <= '0;
      end
      ST_RUN: begin
        if (issue_fire) begin
          addr_r <= addr_r + 1'b1;
          k_r    <= k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and read launch
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    issue_fire = 1'b0;
    is_last    = (k_r == INNER_W'(inner_r - 1'b1));
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && (in_operation == OP_GATHER)) state_nxt = ST_WRAP;
      end
      ST_WRAP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_RUN;
      ST_RUN: begin
        issue_fire = can_issue;
        if (can_issue && is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    issue.valid = issue_fire;
    issue.last  = is_last;
    issue.err   = bad_r || (addr_r >= SPAN_W'(STORE_WORDS));
  end

  `TGE_ASSERT(a_k_in_slice, (state_r == ST_RUN) |-> (k_r < inner_r), "slice count overran")
  `TGE_ASSERT(a_last_ends, (issue.valid && issue.last) |=> (state_r == ST_IDLE), "last read did not end item")
  `TGE_ASSERT(a_inner_clamped, (state_r == ST_RUN) |-> (inner_r != '0 && inner_r <= INNER_W'(MAX_INNER)), "slice length out of range")
  `TGE_ASSERT(a_no_accept_busy, (state_r != ST_IDLE) |-> !ram_we, "load taken while gathering")

endmodule
`default_nettype wire

// ===== src/tge_obuf.sv =====
// Output queue: two-entry buffer that catches store read data and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
`include "tensor_gather_engine_top_macros.svh"
module tge_obuf import tge_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tge_issue_t            issue,
  input  wire logic [WORD_BITS-1:0]  rd_data,
  output logic                       can_issue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_WORD_W-1:0]      out_word,
  output logic                       out_last,
  output logic                       out_err
);

  tge_issue_t pend_r;
  tge_entry_t fifo_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;
  tge_entry_t push_entry;

  assign push = pend_r.valid;
  assign pop  = out_valid && out_ready;

  always_comb begin
    push_entry.word = pend_r.err ? '0 : rd_data;
    push_entry.last = pend_r.last;
    push_entry.err  = pend_r.err;
    count_nxt       = count_r - {1'b0, pop} + {1'b0, push};
    // a read launched now is pushed from pend_r once its store data returns
    can_issue       = (count_nxt < 2'd2);
  end

  // tracks the read that is in flight in the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r.valid <= 1'b0;
    end else begin
      pend_r.valid <= issue.valid;
    end
    pend_r.last <= issue.last;
    pend_r.err  <= issue.err;
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= push_entry;
  end

  assign out_valid = (count_r != 2'd0);
  assign out_word  = OUT_WORD_W'(fifo_r[rd_ptr_r].word);
  assign out_last  = fifo_r[rd_ptr_r].last;
  assign out_err   = fifo_r[rd_ptr_r].err;

  `TGE_ASSERT(a_count_max, count_r != 2'd3, "queue count out of range")
  `TGE_ASSERT(a_no_overflow, !(push && !pop && count_r == 2'd2), "word pushed into full queue")
  `TGE_ASSERT(a_idle_stays, (count_r == 2'd0 && !pend_r.valid) |=> (count_r == 2'd0), "word appeared from nothing")

endmodule
`default_nettype wire
